// ----- hw/rtl/bfsmf_pkg.sv -----
// Constants and codes shared by the max-flow engine.
package bfsmf_pkg;
	localparam int MAX_NODES = 64;
	localparam int MAX_ARCS  = 512;
	localparam int CAP_BITS  = 32;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int ARC_W     = $clog2(MAX_ARCS);
	localparam int APTR_W    = ARC_W + 1;
	localparam int QPTR_W    = NODE_W + 1;
	localparam int FLOW_W    = 48;
	localparam int CNT_W     = 7;

	localparam logic [APTR_W-1:0] NO_ARC = APTR_W'(MAX_ARCS);
	localparam logic [CNT_W-1:0]  NODE_COUNT_RST = CNT_W'(MAX_NODES);

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_ADD     = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_SAME_END = 2'd3
	} status_t;

	localparam logic [2:0] REG_NODE_COUNT = 3'd0;
endpackage

// ----- hw/rtl/bfs_augmenting_path_max_flow.sv -----
// Edmonds-Karp max-flow engine over an arc table held in synchronous memories.
//
//  channel | signals                                               | accepted when
//  in      | in_valid in_ready operation from_node to_node capacity | in_valid & in_ready
//  out     | out_valid out_ready status max_flow                   | out_valid & out_ready
//  cfg     | psel penable pwrite paddr pwdata prdata pready        | psel & penable & pwrite
//
// Clear and error items go straight to the result state; add-edge items pass first through S_ADD0 to S_ADD3.
// A compute item runs per path: one search that dequeues nodes and checks the arcs of each
// (stopping at the sink), then a walk back for the bottleneck and one to update residuals.
// Reset empties all lists through per-node valid bits; no memory sweep is needed.
// A new item is taken once the previous result is in the output register.
module bfs_augmenting_path_max_flow (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [bfsmf_pkg::NODE_W-1:0]  from_node,
	input  logic [bfsmf_pkg::NODE_W-1:0]  to_node,
	input  logic [31:0]                   capacity,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bfsmf_pkg::FLOW_W-1:0]  max_flow,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import bfsmf_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3,
		S_BFS_INIT, S_Q_RD, S_Q_WAIT, S_FIRST, S_ARC_RD, S_ARC_CHK,
		S_P1_RD, S_P1_WAIT, S_P1_USE,
		S_P2_RD, S_P2_WAIT, S_P2_SUB, S_P2_ADD,
		S_ACCUM, S_FIN
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]    node_count_q;
	logic [MAX_NODES-1:0] node_v_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [APTR_W-1:0]   arcs_used_q;
	logic [NODE_W-1:0]   from_q, to_q, u_q, v_q;
	logic [CAP_BITS-1:0] cap_q, bott_q;
	logic [APTR_W-1:0]   a_q;
	logic [QPTR_W-1:0]   head_q, tail_q;
	logic [QPTR_W-1:0]   steps_q;
	logic [FLOW_W-1:0]   flow_q;
	logic [1:0]          res_status_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [FLOW_W-1:0]   max_flow_q;

	// memories
	logic [NODE_W-1:0]   tgt_mem [MAX_ARCS];
	logic [CAP_BITS-1:0] res_mem [MAX_ARCS];
	logic [APTR_W-1:0]   nxt_mem [MAX_ARCS];
	logic [ARC_W-1:0]    first_mem [MAX_NODES];
	logic [ARC_W-1:0]    last_mem [MAX_NODES];
	logic [ARC_W-1:0]    parent_mem [MAX_NODES];
	logic [NODE_W-1:0]   queue_mem [MAX_NODES];

	logic                tgt_we, res_we, nxt_we, first_we, last_we, parent_we, queue_we;
	logic [ARC_W-1:0]    tgt_wa, res_wa, nxt_wa, tgt_ra, res_ra_a, res_ra_b, nxt_ra;
	logic [NODE_W-1:0]   tgt_wd, first_wa, last_wa, parent_wa, queue_wa;
	logic [NODE_W-1:0]   first_ra, last_ra, parent_ra, queue_ra, queue_wd;
	logic [CAP_BITS-1:0] res_wd;
	logic [APTR_W-1:0]   nxt_wd;
	logic [ARC_W-1:0]    first_wd, last_wd, parent_wd;
	logic [NODE_W-1:0]   tgt_rd, queue_rd;
	logic [CAP_BITS-1:0] res_rd_a, res_rd_b;
	logic [APTR_W-1:0]   nxt_rd;
	logic [ARC_W-1:0]    first_rd, last_rd, parent_rd;

	always_ff @(posedge clk) begin
		if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
		tgt_rd <= tgt_mem[tgt_ra];
	end
	always_ff @(posedge clk) begin
		if (res_we) res_mem[res_wa] <= res_wd;
		res_rd_a <= res_mem[res_ra_a];
		res_rd_b <= res_mem[res_ra_b];
	end
	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		nxt_rd <= nxt_mem[nxt_ra];
	end
	always_ff @(posedge clk) begin
		if (first_we) first_mem[first_wa] <= first_wd;
		first_rd <= first_mem[first_ra];
	end
	always_ff @(posedge clk) begin
		if (last_we) last_mem[last_wa] <= last_wd;
		last_rd <= last_mem[last_ra];
	end
	always_ff @(posedge clk) begin
		if (parent_we) parent_mem[parent_wa] <= parent_wd;
		parent_rd <= parent_mem[parent_ra];
	end
	always_ff @(posedge clk) begin
		if (queue_we) queue_mem[queue_wa] <= queue_wd;
		queue_rd <= queue_mem[queue_ra];
	end

	logic [CNT_W-1:0]  limit;
	logic              range_err;
	logic [ARC_W-1:0]  fw_arc, bw_arc, last_to;
	logic [NODE_W-1:0] w_node;
	logic              take_arc;
	logic [FLOW_W:0]   flow_sum;
	logic              cfg_wr;
	logic              fin_fire;

	assign limit     = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
	assign range_err = ({1'b0, from_node} >= limit) || ({1'b0, to_node} >= limit);
	assign fw_arc    = arcs_used_q[ARC_W-1:0];
	assign bw_arc    = fw_arc | ARC_W'(1);
	assign last_to   = (to_q == from_q) ? fw_arc : last_rd;
	assign w_node    = tgt_rd;
	assign take_arc  = !visited_q[w_node] && (res_rd_a != '0) && !tail_q[QPTR_W-1];
	assign flow_sum  = {1'b0, flow_q} + (FLOW_W+1)'(bott_q);
	assign cfg_wr    = psel && penable && pwrite && (paddr == REG_NODE_COUNT);
	assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign max_flow  = max_flow_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr == REG_NODE_COUNT) ? {{(32-CNT_W){1'b0}}, node_count_q} : '0;

	always_comb begin
		tgt_we = 1'b0; tgt_wa = fw_arc; tgt_wd = to_q; tgt_ra = a_q[ARC_W-1:0];
		res_we = 1'b0; res_wa = fw_arc; res_wd = cap_q;
		res_ra_a = a_q[ARC_W-1:0]; res_ra_b = a_q[ARC_W-1:0] ^ ARC_W'(1);
		nxt_we = 1'b0; nxt_wa = fw_arc; nxt_wd = NO_ARC; nxt_ra = a_q[ARC_W-1:0];
		first_we = 1'b0; first_wa = from_q; first_wd = fw_arc; first_ra = queue_rd;
		last_we = 1'b0; last_wa = from_q; last_wd = fw_arc; last_ra = from_q;
		parent_we = 1'b0; parent_wa = w_node; parent_wd = a_q[ARC_W-1:0]; parent_ra = v_q;
		queue_we = 1'b0; queue_wa = tail_q[NODE_W-1:0]; queue_wd = w_node;
		queue_ra = head_q[NODE_W-1:0];
		case (state_q)
			S_ADD0: begin
				tgt_we = 1'b1; res_we = 1'b1; nxt_we = 1'b1;
			end
			S_ADD1: begin
				tgt_we = 1'b1; tgt_wa = bw_arc; tgt_wd = from_q;
				res_we = 1'b1; res_wa = bw_arc; res_wd = '0;
				nxt_we = 1'b1; nxt_wa = bw_arc;
			end
			S_ADD2: begin
				nxt_wa = last_rd; nxt_wd = {1'b0, fw_arc};
				nxt_we = node_v_q[from_q];
				first_we = !node_v_q[from_q];
				last_we = 1'b1;
				last_ra = to_q;
			end
			S_ADD3: begin
				nxt_wa = last_to; nxt_wd = {1'b0, bw_arc};
				nxt_we = node_v_q[to_q];
				first_we = !node_v_q[to_q]; first_wa = to_q; first_wd = bw_arc;
				last_we = 1'b1; last_wa = to_q; last_wd = bw_arc;
			end
			S_BFS_INIT: begin
				queue_we = 1'b1; queue_wa = '0; queue_wd = from_q;
			end
			S_ARC_CHK: begin
				parent_we = take_arc;
				queue_we = take_arc;
			end
			S_P1_WAIT: begin
				res_ra_a = parent_rd;
				tgt_ra = parent_rd ^ ARC_W'(1);
			end
			S_P2_WAIT: begin
				res_ra_a = parent_rd;
				res_ra_b = parent_rd ^ ARC_W'(1);
				tgt_ra = parent_rd ^ ARC_W'(1);
			end
			S_P2_SUB: begin
				res_we = 1'b1; res_wa = a_q[ARC_W-1:0]; res_wd = res_rd_a - bott_q;
			end
			S_P2_ADD: begin
				res_we = 1'b1; res_wa = a_q[ARC_W-1:0] ^ ARC_W'(1); res_wd = res_rd_b + bott_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= NODE_COUNT_RST;
			node_v_q     <= '0;
			visited_q    <= '0;
			arcs_used_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) node_count_q <= pwdata[CNT_W-1:0];
			if (fin_fire) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						from_q <= from_node;
						to_q <= to_node;
						cap_q <= capacity;
						flow_q <= '0;
						case (operation)
							OP_CLEAR: begin
								node_v_q <= '0;
								arcs_used_q <= '0;
								res_status_q <= ST_OK;
								state_q <= S_FIN;
							end
							OP_ADD: begin
								if (range_err) begin
									res_status_q <= ST_RANGE;
									state_q <= S_FIN;
								end else if (arcs_used_q > APTR_W'(MAX_ARCS - 2)) begin
									res_status_q <= ST_FULL;
									state_q <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									state_q <= S_ADD0;
								end
							end
							OP_COMPUTE: begin
								if (range_err) begin
									res_status_q <= ST_RANGE;
									state_q <= S_FIN;
								end else if (from_node == to_node) begin
									res_status_q <= ST_SAME_END;
									state_q <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									state_q <= S_BFS_INIT;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ADD0: state_q <= S_ADD1;
				S_ADD1: state_q <= S_ADD2;
				S_ADD2: begin
					node_v_q[from_q] <= 1'b1;
					state_q <= S_ADD3;
				end
				S_ADD3: begin
					node_v_q[to_q] <= 1'b1;
					arcs_used_q <= arcs_used_q + APTR_W'(2);
					state_q <= S_FIN;
				end
				S_BFS_INIT: begin
					visited_q <= MAX_NODES'(1) << from_q;
					head_q <= '0;
					tail_q <= QPTR_W'(1);
					state_q <= S_Q_RD;
				end
				S_Q_RD: begin
					bott_q <= '1;
					v_q <= to_q;
					steps_q <= '0;
					if (head_q < tail_q) begin
						head_q <= head_q + QPTR_W'(1);
						state_q <= S_Q_WAIT;
					end else begin
						state_q <= visited_q[to_q] ? S_P1_RD : S_FIN;
					end
				end
				S_Q_WAIT: begin
					u_q <= queue_rd;
					if (queue_rd == to_q) state_q <= visited_q[to_q] ? S_P1_RD : S_FIN;
					else state_q <= S_FIRST;
				end
				S_FIRST: begin
					a_q <= node_v_q[u_q] ? {1'b0, first_rd} : NO_ARC;
					state_q <= S_ARC_RD;
				end
				S_ARC_RD: begin
					state_q <= (a_q < arcs_used_q) ? S_ARC_CHK : S_Q_RD;
				end
				S_ARC_CHK: begin
					if (take_arc) begin
						visited_q[w_node] <= 1'b1;
						tail_q <= tail_q + QPTR_W'(1);
					end
					a_q <= nxt_rd;
					state_q <= S_ARC_RD;
				end
				S_P1_RD: begin
					if (v_q != from_q && !steps_q[QPTR_W-1]) begin
						state_q <= S_P1_WAIT;
					end else begin
						v_q <= to_q;
						steps_q <= '0;
						state_q <= S_P2_RD;
					end
				end
				S_P1_WAIT: begin
					a_q <= {1'b0, parent_rd};
					state_q <= S_P1_USE;
				end
				S_P1_USE: begin
					if (res_rd_a < bott_q) bott_q <= res_rd_a;
					v_q <= tgt_rd;
					steps_q <= steps_q + QPTR_W'(1);
					state_q <= S_P1_RD;
				end
				S_P2_RD: begin
					state_q <= (v_q != from_q && !steps_q[QPTR_W-1]) ? S_P2_WAIT : S_ACCUM;
				end
				S_P2_WAIT: begin
					a_q <= {1'b0, parent_rd};
					state_q <= S_P2_SUB;
				end
				S_P2_SUB: begin
					v_q <= tgt_rd;
					state_q <= S_P2_ADD;
				end
				S_P2_ADD: begin
					steps_q <= steps_q + QPTR_W'(1);
					state_q <= S_P2_RD;
				end
				S_ACCUM: begin
					if (bott_q == '0) begin
						state_q <= S_FIN;
					end else begin
						flow_q <= flow_sum[FLOW_W] ? '1 : flow_sum[FLOW_W-1:0];
						state_q <= S_BFS_INIT;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						status_q <= res_status_q;
						max_flow_q <= flow_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
